// ----- sv/irn_pkg.sv -----
// shared types, constants and symbol tables for the integer to roman numeral converter
package irn_pkg;

  localparam int unsigned ValueWidth  = 12;
  localparam int unsigned SymWidth    = 7;
  localparam int unsigned NumDigits   = 4;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned PosWidth    = 2;
  localparam int unsigned IdxWidth    = 2;
  localparam int unsigned LenWidth    = 3;
  localparam int unsigned MaxValue    = 3999;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = 1;
  localparam int unsigned QueueCntW   = 2;

  // digit positions, most significant first
  localparam logic [PosWidth-1:0] PosThou = 2'd0;
  localparam logic [PosWidth-1:0] PosHund = 2'd1;
  localparam logic [PosWidth-1:0] PosTens = 2'd2;
  localparam logic [PosWidth-1:0] PosUnit = 2'd3;

  localparam logic [SymWidth-1:0] SymNone = 7'h00;
  localparam logic [SymWidth-1:0] SymI    = 7'h49;
  localparam logic [SymWidth-1:0] SymV    = 7'h56;
  localparam logic [SymWidth-1:0] SymX    = 7'h58;
  localparam logic [SymWidth-1:0] SymL    = 7'h4C;
  localparam logic [SymWidth-1:0] SymC    = 7'h43;
  localparam logic [SymWidth-1:0] SymD    = 7'h44;
  localparam logic [SymWidth-1:0] SymM    = 7'h4D;

  // decimal digits of one item, as handed from the front part to the back part
  typedef struct packed {
    logic                                 err;
    logic [NumDigits-1:0][DigitWidth-1:0] dig;
  } digits_t;

  function automatic logic [LenWidth-1:0] dig_len(input logic [DigitWidth-1:0] d);
    logic [LenWidth-1:0] len;
    case (d)
      4'd0:    len = 3'd0;
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      4'd9:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [SymWidth-1:0] sym_one(input logic [PosWidth-1:0] pos);
    logic [SymWidth-1:0] s;
    case (pos)
      PosThou: s = SymM;
      PosHund: s = SymC;
      PosTens: s = SymX;
      PosUnit: s = SymI;
      default: s = SymNone;
    endcase
    return s;
  endfunction

  function automatic logic [SymWidth-1:0] sym_five(input logic [PosWidth-1:0] pos);
    logic [SymWidth-1:0] s;
    case (pos)
      PosHund: s = SymD;
      PosTens: s = SymL;
      PosUnit: s = SymV;
      default: s = SymNone;
    endcase
    return s;
  endfunction

  function automatic logic [SymWidth-1:0] sym_ten(input logic [PosWidth-1:0] pos);
    logic [SymWidth-1:0] s;
    case (pos)
      PosHund: s = SymM;
      PosTens: s = SymC;
      PosUnit: s = SymX;
      default: s = SymNone;
    endcase
    return s;
  endfunction

  // character number idx of digit d written at position pos
  function automatic logic [SymWidth-1:0] dig_sym(input logic [DigitWidth-1:0] d,
                                                  input logic [IdxWidth-1:0]   idx,
                                                  input logic [PosWidth-1:0]   pos);
    logic [SymWidth-1:0] s;
    if (d == 4'd9) begin
      s = (idx == 2'd0) ? sym_one(pos) : sym_ten(pos);
    end else if (d >= 4'd5) begin
      s = (idx == 2'd0) ? sym_five(pos) : sym_one(pos);
    end else if (d == 4'd4) begin
      s = (idx == 2'd0) ? sym_one(pos) : sym_five(pos);
    end else begin
      s = sym_one(pos);
    end
    return s;
  endfunction

endpackage

// ----- sv/irn_front.sv -----
// front part: takes values, checks range and splits them into decimal digits
module irn_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [irn_pkg::ValueWidth-1:0]      value_i,
  output logic                                push_o,
  output irn_pkg::digits_t                    push_data_o,
  input  logic                                full_i
);

  typedef enum logic [2:0] {
    FIdle = 3'b001,
    FConv = 3'b010,
    FPush = 3'b100
  } front_state_e;

  localparam int unsigned RemW = irn_pkg::ValueWidth + 2;

  front_state_e                          state_q, state_d;
  logic [irn_pkg::ValueWidth-1:0]        rem_q, rem_d;
  logic [irn_pkg::PosWidth-1:0]          step_q, step_d;
  logic                                  err_q, err_d;
  logic [irn_pkg::NumDigits-1:0][irn_pkg::DigitWidth-1:0] dig_q, dig_d;

  logic [RemW-1:0]                       scale;
  logic [RemW-1:0]                       sub;
  logic [irn_pkg::DigitWidth-1:0]        digit;
  logic [RemW-1:0]                       rem_wide;

  always_comb begin
    case (step_q)
      irn_pkg::PosThou: scale = RemW'(1000);
      irn_pkg::PosHund: scale = RemW'(100);
      default:          scale = RemW'(10);
    endcase
  end

  // one decimal digit per cycle by parallel compares against its multiples
  always_comb begin
    rem_wide = {2'b00, rem_q};
    sub      = '0;
    digit    = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem_wide >= RemW'(k) * scale) begin
        sub   = RemW'(k) * scale;
        digit = irn_pkg::DigitWidth'(k);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    step_d  = step_q;
    err_d   = err_q;
    dig_d   = dig_q;
    case (state_q)
      FIdle: begin
        if (in_valid_i) begin
          rem_d  = value_i;
          step_d = irn_pkg::PosThou;
          err_d  = (value_i == '0) || (value_i > irn_pkg::ValueWidth'(irn_pkg::MaxValue));
          dig_d  = '0;
          state_d = err_d ? FPush : FConv;
        end
      end
      FConv: begin
        dig_d[step_q] = digit;
        rem_d = irn_pkg::ValueWidth'(rem_wide - sub);
        if (step_q == irn_pkg::PosTens) begin
          dig_d[irn_pkg::PosUnit] = rem_d[irn_pkg::DigitWidth-1:0];
          state_d = FPush;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      FPush: begin
        if (!full_i) begin
          state_d = FIdle;
        end
      end
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    step_q <= step_d;
    err_q  <= err_d;
    dig_q  <= dig_d;
  end

  assign in_stall_o       = (state_q != FIdle);
  assign push_o           = (state_q == FPush) && !full_i;
  assign push_data_o.err  = err_q;
  assign push_data_o.dig  = dig_q;

endmodule

// ----- sv/irn_queue.sv -----
// short queue of digit sets between the front and back parts
module irn_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  irn_pkg::digits_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output irn_pkg::digits_t data_o
);

  irn_pkg::digits_t                mem_q [irn_pkg::QueueDepth];
  logic [irn_pkg::QueuePtrW-1:0]   wr_q, rd_q;
  logic [irn_pkg::QueueCntW-1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + irn_pkg::QueueCntW'(push_i) - irn_pkg::QueueCntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign full_o  = (cnt_q == irn_pkg::QueueCntW'(irn_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

endmodule

// ----- sv/irn_back.sv -----
// back part: writes out the numeral one character per transfer
module irn_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  irn_pkg::digits_t                  q_data_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [irn_pkg::SymWidth-1:0]      symbol_o,
  output logic                              last_o,
  output logic                              out_of_range_o
);

  logic                                                   busy_q;
  logic                                                   err_q;
  logic [irn_pkg::NumDigits-1:0][irn_pkg::DigitWidth-1:0] dig_q;
  logic [irn_pkg::PosWidth-1:0]                           pos_q;
  logic [irn_pkg::IdxWidth-1:0]                           idx_q;
  logic                                                   out_valid_q;
  logic [irn_pkg::SymWidth-1:0]                           symbol_q;
  logic                                                   last_q;
  logic                                                   oor_q;

  logic [irn_pkg::DigitWidth-1:0] cur;
  logic [irn_pkg::LenWidth-1:0]   len;
  logic                           digit_end;
  logic                           nxt_found;
  logic [irn_pkg::PosWidth-1:0]   nxt_pos;
  logic [irn_pkg::PosWidth-1:0]   first_pos;
  logic                           can_emit;
  logic                           emit_last;
  logic [irn_pkg::SymWidth-1:0]   sym;

  always_comb begin
    cur       = dig_q[pos_q];
    len       = irn_pkg::dig_len(cur);
    digit_end = ({1'b0, idx_q} + 3'd1) == len;
    sym       = err_q ? irn_pkg::SymNone : irn_pkg::dig_sym(cur, idx_q, pos_q);
    nxt_found = 1'b0;
    nxt_pos   = pos_q;
    for (int p = irn_pkg::NumDigits - 1; p >= 0; p--) begin
      if ((irn_pkg::PosWidth'(p) > pos_q) && (dig_q[p] != '0)) begin
        nxt_found = 1'b1;
        nxt_pos   = irn_pkg::PosWidth'(p);
      end
    end
    first_pos = irn_pkg::PosUnit;
    for (int p = irn_pkg::NumDigits - 1; p >= 0; p--) begin
      if (q_data_i.dig[p] != '0) begin
        first_pos = irn_pkg::PosWidth'(p);
      end
    end
  end

  assign can_emit  = busy_q && (!out_valid_q || !out_stall_i);
  assign emit_last = err_q || (digit_end && !nxt_found);
  assign pop_o     = q_valid_i && (!busy_q || (can_emit && emit_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (can_emit && emit_last) begin
        busy_q <= 1'b0;
      end
      if (can_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      err_q <= q_data_i.err;
      dig_q <= q_data_i.dig;
      pos_q <= first_pos;
      idx_q <= '0;
    end else if (can_emit) begin
      if (digit_end) begin
        pos_q <= nxt_pos;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
    if (can_emit) begin
      symbol_q <= sym;
      last_q   <= emit_last;
      oor_q    <= err_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = symbol_q;
  assign last_o         = last_q;
  assign out_of_range_o = oor_q;

endmodule

// ----- sv/integer_to_roman_numeral.sv -----
// top level of the integer to roman numeral converter
// Converts a 12-bit value from 1 to 3999 into its Roman numeral, one uppercase ASCII
// character per output transfer, left to right, with last_o on the final character.
// A value of 0 or above 3999 gives a single transfer with symbol 0, last_o and
// out_of_range_o set. The front part takes no new value until it has pushed the
// digits of the current one into the queue; it finds one decimal digit per cycle
// by compare and subtract. The back part gives one character per cycle while
// out_stall_i is low; a numeral has 1 to 15 characters, and a two-entry queue
// between the parts lets the front convert the next value while the back is still
// writing out the current one.
module integer_to_roman_numeral (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [irn_pkg::ValueWidth-1:0]    value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [irn_pkg::SymWidth-1:0]      symbol_o,
  output logic                              last_o,
  output logic                              out_of_range_o
);

  logic             push;
  logic             full;
  logic             pop;
  logic             q_valid;
  irn_pkg::digits_t push_data;
  irn_pkg::digits_t q_data;

  irn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  irn_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  irn_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_o       (symbol_o),
    .last_o         (last_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule
